### hw/rtl/wps_pkg.sv
package wps_pkg;

  // Defaults for the top-level parameters.
  localparam int START_LIMIT_DEF = 20;
  localparam int TIMEOUT_BITS_DEF = 32;

  // Opcodes of an input item.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_CMD     = 3'd1;
  localparam logic [2:0] OP_KSTART  = 3'd2;
  localparam logic [2:0] OP_PET     = 3'd3;
  localparam logic [2:0] OP_RESTART = 3'd4;

  // Special command values.
  localparam int CMD_FORCE_RESET = -1;
  localparam int CMD_OFF_ON      = -101;
  localparam int CMD_OFF_OFF     = -100;

  // Watchdog control writes.
  localparam logic [1:0] WD_NONE    = 2'd0;
  localparam logic [1:0] WD_ENABLE  = 2'd1;
  localparam logic [1:0] WD_DISABLE = 2'd2;

  // Boot stages.
  localparam logic [1:0] STAGE_NONE      = 2'd0;
  localparam logic [1:0] STAGE_KERNEL    = 2'd2;
  localparam logic [1:0] STAGE_FRAMEWORK = 2'd3;

  // Persistent offline bit writes.
  localparam logic [1:0] PERS_NONE  = 2'd0;
  localparam logic [1:0] PERS_SET   = 2'd1;
  localparam logic [1:0] PERS_CLEAR = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_DONE       = 2'd0;
  localparam logic [1:0] STAT_IGNORED    = 2'd1;
  localparam logic [1:0] STAT_INVALID    = 2'd2;
  localparam logic [1:0] STAT_SUPPRESSED = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_PET_INTERVAL    = 3'd0;
  localparam logic [2:0] REG_MINIMUM_TIME    = 3'd1;
  localparam logic [2:0] REG_BOOT_NORMAL     = 3'd2;
  localparam logic [2:0] REG_CHARGING_MODE   = 3'd3;
  localparam logic [2:0] REG_OFFLINE_AT_BOOT = 3'd4;

  // Register reset values.
  localparam logic [7:0] PET_INTERVAL_RST = 8'd100;
  localparam logic [7:0] MINIMUM_TIME_RST = 8'd1;

  localparam int ADDR_W = 5;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] command_value;
  } item_t;

  typedef struct packed {
    logic               pet_pulse;
    logic [1:0]         wd_control;
    logic [1:0]         stage_flags;
    logic               reset_request;
    logic [1:0]         persist_offline;
    logic [1:0]         status;
    logic signed [31:0] monitor_value;
  } result_t;

  typedef struct packed {
    logic [7:0] pet_interval;
    logic [7:0] minimum_time;
    logic       boot_normal;
    logic       charging_mode;
    logic       offline_at_boot;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic fin;
    logic push;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

### hw/rtl/wps_ctrl.sv
module wps_ctrl #(
  parameter int TIMEOUT_BITS = wps_pkg::TIMEOUT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  output logic          result_valid,
  input  logic          result_stall,
  input  wps_pkg::sts_t sts,
  output wps_pkg::cmd_t cmd
);

  localparam int CntW = $clog2(TIMEOUT_BITS);
  localparam logic [CntW-1:0] Last = CntW'(TIMEOUT_BITS - 1);

  typedef enum logic [2:0] {
    IDLE,
    EXEC,
    DIV,
    FIN,
    PUSH
  } state_t;

  state_t          state;
  logic [CntW-1:0] cnt;

  // Command decode from the current state.
  always_comb begin
    cmd.load     = (state == IDLE) && item_valid;
    cmd.exec     = (state == EXEC);
    cmd.div_step = (state == DIV);
    cmd.fin      = (state == FIN);
    cmd.push     = (state == PUSH) && (!result_valid || !result_stall);
  end

  assign item_stall = (state != IDLE);

  // Sequencer state, division step count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (item_valid) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          cnt <= '0;
          if (sts.need_div) begin
            state <= DIV;
          end else begin
            state <= PUSH;
          end
        end
        DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == Last) begin
            state <= FIN;
          end
        end
        FIN: begin
          state <= PUSH;
        end
        PUSH: begin
          if (cmd.push) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == DIV && cnt == Last) |=> (state == FIN))
    else $error("division did not end after the last step");

  a_no_div: assert property (@(posedge clk) disable iff (rst)
    (state == EXEC && !sts.need_div) |=> (state == PUSH))
    else $error("item without division did not go to push");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == PUSH && result_valid && result_stall) |=> (state == PUSH))
    else $error("pending result left while output was stalled");

  a_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == EXEC && item_stall))
    else $error("accepted transaction not executed");

endmodule

### hw/rtl/wps_dp.sv
module wps_dp #(
  parameter int START_LIMIT  = wps_pkg::START_LIMIT_DEF,
  parameter int TIMEOUT_BITS = wps_pkg::TIMEOUT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  wps_pkg::cfg_t    cfg,
  input  wps_pkg::item_t   item,
  input  wps_pkg::cmd_t    cmd,
  output wps_pkg::sts_t    sts,
  output wps_pkg::result_t result
);

  localparam int TW = TIMEOUT_BITS;
  localparam logic signed [TW-1:0] CmdForceReset = TW'(wps_pkg::CMD_FORCE_RESET);
  localparam logic signed [TW-1:0] CmdOffOn      = TW'(wps_pkg::CMD_OFF_ON);
  localparam logic signed [TW-1:0] CmdOffOff     = TW'(wps_pkg::CMD_OFF_OFF);

  // Latched item.
  logic [2:0]           op_q;
  logic signed [TW-1:0] v_q;

  // Supervisor state.
  logic signed [TW-1:0] mon;
  logic [1:0]           stage;
  logic                 latch;
  logic [4:0]           starts;
  logic [31:0]          cycles;
  logic [7:0]           rem;
  logic [7:0]           cur;
  logic [7:0]           secs;
  logic                 run;

  // Next values for the execute step.
  logic signed [TW-1:0] mon_next;
  logic [1:0]           stage_next;
  logic                 latch_next;
  logic [4:0]           starts_next;
  logic [31:0]          cycles_next;
  logic [7:0]           rem_next;
  logic [7:0]           cur_next;
  logic [7:0]           secs_next;
  logic                 run_next;
  wps_pkg::result_t     res_next;
  logic                 do_start;
  logic [31:0]          cyc_dec;

  // Divider registers.
  logic [TW-1:0] dq;
  logic [7:0]    dr;
  logic [8:0]    dr_sh;
  logic          q_bit;
  logic [31:0]   q_sat;

  wps_pkg::result_t res;

  logic       offline;
  logic [7:0] iv;
  logic signed [TW-1:0] min_ext;

  assign offline = latch || cfg.offline_at_boot || !cfg.boot_normal;
  assign iv      = (cfg.pet_interval == 8'd0) ? 8'd1 : cfg.pet_interval;
  assign min_ext = $signed({{(TW - 8){1'b0}}, cfg.minimum_time});

  // Execute step: everything but the interval split.
  always_comb begin
    mon_next    = mon;
    stage_next  = stage;
    latch_next  = latch;
    starts_next = starts;
    cycles_next = cycles;
    rem_next    = rem;
    cur_next    = cur;
    secs_next   = secs;
    run_next    = run;
    res_next    = '0;
    do_start    = 1'b0;
    sts.need_div = 1'b0;
    cyc_dec     = (cycles != 32'd0) ? (cycles - 32'd1) : cycles;

    case (op_q)
      wps_pkg::OP_TICK: begin
        if (run) begin
          if (secs > 8'd1) begin
            secs_next = secs - 8'd1;
          end else begin
            cycles_next = cyc_dec;
            if (cyc_dec != 32'd0) begin
              cur_next           = iv;
              secs_next          = iv;
              res_next.pet_pulse = 1'b1;
            end else if (rem > cfg.minimum_time) begin
              cur_next           = rem;
              secs_next          = rem;
              rem_next           = 8'd0;
              res_next.pet_pulse = 1'b1;
            end else begin
              run_next = 1'b0;
              if (!cfg.charging_mode) begin
                res_next.wd_control    = wps_pkg::WD_ENABLE;
                res_next.stage_flags   = stage;
                res_next.reset_request = 1'b1;
              end
            end
          end
        end
      end
      wps_pkg::OP_CMD: begin
        if (cfg.charging_mode || !cfg.boot_normal) begin
          res_next.status = wps_pkg::STAT_IGNORED;
        end else begin
          mon_next   = v_q;
          stage_next = wps_pkg::STAGE_FRAMEWORK;
          if (v_q == CmdForceReset || starts == 5'd0) begin
            res_next.wd_control    = wps_pkg::WD_ENABLE;
            res_next.stage_flags   = wps_pkg::STAGE_FRAMEWORK;
            res_next.reset_request = 1'b1;
          end else if (v_q == CmdOffOn) begin
            latch_next               = 1'b1;
            res_next.persist_offline = wps_pkg::PERS_SET;
            res_next.wd_control      = wps_pkg::WD_DISABLE;
            run_next                 = 1'b0;
            cycles_next              = 32'd0;
            rem_next                 = 8'd0;
          end else if (v_q == CmdOffOff) begin
            res_next.persist_offline = wps_pkg::PERS_CLEAR;
          end else if (v_q == '0) begin
            if (offline) begin
              res_next.status = wps_pkg::STAT_SUPPRESSED;
            end else begin
              stage_next          = wps_pkg::STAGE_NONE;
              res_next.wd_control = wps_pkg::WD_DISABLE;
              run_next            = 1'b0;
              cycles_next         = 32'd0;
              rem_next            = 8'd0;
              mon_next            = '0;
            end
          end else if (v_q < 0) begin
            mon_next        = mon;
            stage_next      = wps_pkg::STAGE_NONE;
            res_next.status = wps_pkg::STAT_INVALID;
          end else begin
            starts_next = starts - 5'd1;
            do_start    = 1'b1;
          end
        end
      end
      wps_pkg::OP_KSTART: begin
        if (offline) begin
          mon_next        = '0;
          res_next.status = wps_pkg::STAT_SUPPRESSED;
        end else begin
          stage_next = wps_pkg::STAGE_KERNEL;
          mon_next   = v_q;
          do_start   = 1'b1;
        end
      end
      wps_pkg::OP_PET: begin
        if (offline) begin
          res_next.status = wps_pkg::STAT_SUPPRESSED;
        end else begin
          res_next.pet_pulse = 1'b1;
        end
      end
      wps_pkg::OP_RESTART: begin
        res_next.wd_control = wps_pkg::WD_DISABLE;
        run_next            = 1'b0;
        cycles_next         = 32'd0;
        rem_next            = 8'd0;
      end
      default: begin
      end
    endcase

    // Start of monitoring; a timeout at or above the minimum needs the split.
    if (do_start) begin
      if (offline) begin
        mon_next        = '0;
        res_next.status = wps_pkg::STAT_SUPPRESSED;
      end else begin
        res_next.wd_control  = wps_pkg::WD_ENABLE;
        res_next.stage_flags = stage_next;
        run_next             = 1'b1;
        cycles_next          = 32'd0;
        rem_next             = 8'd0;
        if (v_q < min_ext) begin
          secs_next = cur;
        end else begin
          sts.need_div = 1'b1;
        end
      end
    end

    res_next.monitor_value = 32'(mon_next);
  end

  // One restoring division step by the effective pet interval.
  assign dr_sh = {dr, dq[TW-1]};
  assign q_bit = (dr_sh >= {1'b0, iv});

  // Quotient saturated to 32 bits.
  generate
    if (TW > 32) begin : g_sat
      assign q_sat = (dq[TW-1:32] != '0) ? 32'hFFFF_FFFF : dq[31:0];
    end else begin : g_nosat
      assign q_sat = 32'(dq);
    end
  endgenerate

  // Item latch, divider and output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= item.opcode;
      v_q  <= TW'(item.command_value);
    end
    if (cmd.exec) begin
      res <= res_next;
      dq  <= v_q;
      dr  <= 8'd0;
    end else if (cmd.div_step) begin
      dq <= {dq[TW-2:0], q_bit};
      dr <= q_bit ? 8'(dr_sh - {1'b0, iv}) : dr_sh[7:0];
    end
    if (cmd.push) begin
      result <= res;
    end
  end

  // Supervisor state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      mon    <= '0;
      stage  <= wps_pkg::STAGE_NONE;
      latch  <= 1'b0;
      starts <= 5'(START_LIMIT);
      cycles <= 32'd0;
      rem    <= 8'd0;
      cur    <= 8'd0;
      secs   <= 8'd0;
      run    <= 1'b0;
    end else if (cmd.exec) begin
      mon    <= mon_next;
      stage  <= stage_next;
      latch  <= latch_next;
      starts <= starts_next;
      cycles <= cycles_next;
      rem    <= rem_next;
      cur    <= cur_next;
      secs   <= secs_next;
      run    <= run_next;
    end else if (cmd.fin) begin
      // A zero quotient means the timeout is shorter than one interval.
      if (dq != '0) begin
        cycles <= q_sat;
        rem    <= dr;
        cur    <= iv;
        secs   <= iv;
      end else begin
        cycles <= 32'd1;
        rem    <= cfg.minimum_time;
        cur    <= dr;
        secs   <= dr;
      end
    end
  end

endmodule

### hw/rtl/watchdog_pet_supervisor.sv
// Watchdog pet supervisor.
// Input channel item/item_valid/item_stall carries one transaction per
// one-second tick, user command, kernel start, direct pet or restart notice.
// Output channel result/result_valid/result_stall returns exactly one result
// per input transaction, in order.
// A result passes the states EXEC and PUSH after its input is accepted; a
// start that splits its timeout also passes DIV and FIN, and the split runs
// on a bit-serial restoring divider, one quotient bit per cycle. The block
// takes one transaction at a time: item_stall stays high until its result
// is pushed to the output register. It takes a new transaction while the
// previous result waits in the output register; the new result then waits
// until the receiver releases result_stall, and item_stall stays high
// meanwhile. Reset (rst, synchronous) clears the monitor state, sets the
// start budget to START_LIMIT and loads the register defaults. Registers
// are written over the APB port at byte address 4*i; the user must write
// them only while no transaction is in flight; the block does not check.
module watchdog_pet_supervisor #(
  parameter int START_LIMIT  = wps_pkg::START_LIMIT_DEF,
  parameter int TIMEOUT_BITS = wps_pkg::TIMEOUT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  wps_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output wps_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wps_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  wps_pkg::cfg_t cfg;
  wps_pkg::cmd_t cmd;
  wps_pkg::sts_t sts;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[wps_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pet_interval    <= wps_pkg::PET_INTERVAL_RST;
      cfg.minimum_time    <= wps_pkg::MINIMUM_TIME_RST;
      cfg.boot_normal     <= 1'b1;
      cfg.charging_mode   <= 1'b0;
      cfg.offline_at_boot <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        wps_pkg::REG_PET_INTERVAL:    cfg.pet_interval    <= pwdata[7:0];
        wps_pkg::REG_MINIMUM_TIME:    cfg.minimum_time    <= pwdata[7:0];
        wps_pkg::REG_BOOT_NORMAL:     cfg.boot_normal     <= pwdata[0];
        wps_pkg::REG_CHARGING_MODE:   cfg.charging_mode   <= pwdata[0];
        wps_pkg::REG_OFFLINE_AT_BOOT: cfg.offline_at_boot <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      wps_pkg::REG_PET_INTERVAL:    prdata = {24'd0, cfg.pet_interval};
      wps_pkg::REG_MINIMUM_TIME:    prdata = {24'd0, cfg.minimum_time};
      wps_pkg::REG_BOOT_NORMAL:     prdata = {31'd0, cfg.boot_normal};
      wps_pkg::REG_CHARGING_MODE:   prdata = {31'd0, cfg.charging_mode};
      wps_pkg::REG_OFFLINE_AT_BOOT: prdata = {31'd0, cfg.offline_at_boot};
      default:                      prdata = 32'd0;
    endcase
  end

  wps_ctrl #(
    .TIMEOUT_BITS(TIMEOUT_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  wps_dp #(
    .START_LIMIT  (START_LIMIT),
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result)
  );

endmodule

### sim/tb_watchdog_pet_supervisor.sv
`timescale 1ns / 100ps

module tb_watchdog_pet_supervisor;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 80;
  localparam int HALT_VALUE = 0;
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;

  // Tracks the supervisor state and queues the result each transaction should produce.
  class supervisor_scoreboard;
    logic [7:0]         pet_interval;
    logic [7:0]         minimum_time;
    logic               boot_normal;
    logic               charging_mode;
    logic               offline_at_boot;
    logic signed [31:0] monitor_timeout;
    logic [1:0]         cur_stage;
    logic               offline_latch;
    logic [4:0]         starts_left;
    logic [31:0]        cycles_left;
    logic [7:0]         remainder_secs;
    logic [7:0]         current_interval;
    logic [7:0]         seconds_left;
    logic               timer_running;
    wps_pkg::result_t   res;
    wps_pkg::result_t   expected_q[$];
    int                 errors;

    function new();
      errors = 0;
      pet_interval = wps_pkg::PET_INTERVAL_RST;
      minimum_time = wps_pkg::MINIMUM_TIME_RST;
      boot_normal = 1'b1;
      charging_mode = 1'b0;
      offline_at_boot = 1'b0;
      monitor_timeout = '0;
      cur_stage = wps_pkg::STAGE_NONE;
      offline_latch = 1'b0;
      starts_left = 5'(wps_pkg::START_LIMIT_DEF);
      cycles_left = '0;
      remainder_secs = '0;
      current_interval = '0;
      seconds_left = '0;
      timer_running = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        wps_pkg::REG_PET_INTERVAL:    pet_interval = value[7:0];
        wps_pkg::REG_MINIMUM_TIME:    minimum_time = value[7:0];
        wps_pkg::REG_BOOT_NORMAL:     boot_normal = value[0];
        wps_pkg::REG_CHARGING_MODE:   charging_mode = value[0];
        wps_pkg::REG_OFFLINE_AT_BOOT: offline_at_boot = value[0];
        default: ;
      endcase
    endfunction

    function bit is_offline();
      return offline_latch || offline_at_boot || !boot_normal;
    endfunction

    // A zero pet interval behaves as one second.
    function logic [7:0] pet_period();
      return (pet_interval == 8'd0) ? 8'd1 : pet_interval;
    endfunction

    function void emergency();
      res.wd_control = wps_pkg::WD_ENABLE;
      res.stage_flags = cur_stage;
      res.reset_request = 1'b1;
    endfunction

    function void disable_all();
      res.wd_control = wps_pkg::WD_DISABLE;
      res.stage_flags = wps_pkg::STAGE_NONE;
      timer_running = 1'b0;
      cycles_left = '0;
      remainder_secs = '0;
    endfunction

    // Splits a timeout into whole pet periods and a remainder. Timeouts under
    // the minimum leave the previous interval in place.
    function void split_timeout(logic signed [31:0] t);
      int          mt;
      logic [31:0] iv;
      logic [31:0] q;
      logic [31:0] r;
      mt = minimum_time;
      iv = {24'd0, pet_period()};
      if (t < mt) return;
      q = t / iv;
      r = t % iv;
      remainder_secs = r[7:0];
      if (q > 0) begin
        cycles_left = q;
        current_interval = iv[7:0];
      end else begin
        current_interval = t[7:0];
        remainder_secs = minimum_time;
        cycles_left = 32'd1;
      end
    endfunction

    function void start_timer(logic signed [31:0] t);
      if (is_offline()) begin
        monitor_timeout = '0;
        res.status = wps_pkg::STAT_SUPPRESSED;
        return;
      end
      disable_all();
      split_timeout(t);
      res.wd_control = wps_pkg::WD_ENABLE;
      res.stage_flags = cur_stage;
      timer_running = 1'b1;
      seconds_left = current_interval;
    endfunction

    function void on_expiry();
      if (cycles_left != 0) cycles_left = cycles_left - 1;
      if (cycles_left > 0) begin
        current_interval = pet_period();
      end else if (remainder_secs > minimum_time) begin
        current_interval = remainder_secs;
        remainder_secs = '0;
      end else begin
        timer_running = 1'b0;
        if (!charging_mode) emergency();
        return;
      end
      res.pet_pulse = 1'b1;
      seconds_left = current_interval;
    endfunction

    function void user_command(logic signed [31:0] v);
      logic signed [31:0] old;
      old = monitor_timeout;
      if (charging_mode || !boot_normal) begin
        res.status = wps_pkg::STAT_IGNORED;
        return;
      end
      monitor_timeout = v;
      cur_stage = wps_pkg::STAGE_FRAMEWORK;
      if (v == wps_pkg::CMD_FORCE_RESET || starts_left == 0) begin
        emergency();
      end else if (v == wps_pkg::CMD_OFF_ON) begin
        offline_latch = 1'b1;
        res.persist_offline = wps_pkg::PERS_SET;
        disable_all();
      end else if (v == wps_pkg::CMD_OFF_OFF) begin
        res.persist_offline = wps_pkg::PERS_CLEAR;
      end else if (v == HALT_VALUE) begin
        if (is_offline()) begin
          res.status = wps_pkg::STAT_SUPPRESSED;
        end else begin
          cur_stage = wps_pkg::STAGE_NONE;
          disable_all();
          monitor_timeout = '0;
        end
      end else if (v < 0) begin
        monitor_timeout = old;
        cur_stage = wps_pkg::STAGE_NONE;
        res.status = wps_pkg::STAT_INVALID;
      end else begin
        starts_left = starts_left - 5'd1;
        start_timer(v);
      end
    endfunction

    // Called for every accepted input transaction.
    function void note_item(wps_pkg::item_t it);
      res = '0;
      case (it.opcode)
        wps_pkg::OP_TICK: begin
          if (timer_running) begin
            if (seconds_left > 1) seconds_left = seconds_left - 1;
            else on_expiry();
          end
        end
        wps_pkg::OP_CMD: user_command(it.command_value);
        wps_pkg::OP_KSTART: begin
          if (is_offline()) begin
            monitor_timeout = '0;
            res.status = wps_pkg::STAT_SUPPRESSED;
          end else begin
            cur_stage = wps_pkg::STAGE_KERNEL;
            monitor_timeout = it.command_value;
            start_timer(it.command_value);
          end
        end
        wps_pkg::OP_PET: begin
          if (is_offline()) res.status = wps_pkg::STAT_SUPPRESSED;
          else res.pet_pulse = 1'b1;
        end
        wps_pkg::OP_RESTART: disable_all();
        default: ;
      endcase
      res.monitor_value = monitor_timeout;
      expected_q.push_back(res);
    endfunction

    function string show(wps_pkg::result_t r);
      return $sformatf("pet=%0d ctl=%0d stage=%0d rst=%0d pers=%0d stat=%0d mon=%0d",
                       r.pet_pulse, r.wd_control, r.stage_flags, r.reset_request,
                       r.persist_offline, r.status, r.monitor_value);
    endfunction

    // Called for every accepted output transaction.
    function void check_result(wps_pkg::result_t got);
      wps_pkg::result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing pending: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.pet_pulse !== want.pet_pulse || got.wd_control !== want.wd_control ||
          got.stage_flags !== want.stage_flags || got.reset_request !== want.reset_request ||
          got.persist_offline !== want.persist_offline || got.status !== want.status ||
          got.monitor_value !== want.monitor_value) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %s, got %s", show(want), show(got));
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  wps_pkg::item_t             item = '0;
  logic                       result_valid;
  logic                       result_stall;
  wps_pkg::result_t           result;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [wps_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  logic                rx_stall = 1'b0;
  logic                hold_long = 1'b0;
  logic                hold_req = 1'b0;
  bit                  tx_burst = 1'b0;
  bit                  rx_burst = 1'b0;
  int                  items_offered = 0;
  int                  cycle_count = 0;
  supervisor_scoreboard sb = new();

  assign result_stall = rx_stall || hold_long;

  watchdog_pet_supervisor u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offers one input transaction after a random gap and holds it until taken.
  task automatic offer_item(input logic [2:0] op, input logic signed [31:0] val);
    wps_pkg::item_t it;
    int             gap;
    it.opcode = op;
    it.command_value = val;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall !== 1'b0);
    sb.note_item(it);
    items_offered++;
    @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Waits until every expected result has come back and the block has settled.
  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_cfg(input wps_pkg::cfg_t c);
    drain();
    write_reg(wps_pkg::REG_PET_INTERVAL, {24'd0, c.pet_interval});
    write_reg(wps_pkg::REG_MINIMUM_TIME, {24'd0, c.minimum_time});
    write_reg(wps_pkg::REG_BOOT_NORMAL, {31'd0, c.boot_normal});
    write_reg(wps_pkg::REG_CHARGING_MODE, {31'd0, c.charging_mode});
    write_reg(wps_pkg::REG_OFFLINE_AT_BOOT, {31'd0, c.offline_at_boot});
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly plausible timeouts around the pet period, plus the odd boundary,
  // sub-minimum, negative or full-range value.
  function automatic logic signed [31:0] pick_timeout(input int iv, input int mt);
    logic signed [31:0] t;
    case ($urandom_range(0, 9))
      0: t = $urandom_range(0, mt - 1);
      1: t = 0 - int'($urandom_range(1, 1000));
      2: t = $urandom;
      3: begin
        case ($urandom_range(0, 4))
          0: t = iv - 1;
          1: t = iv;
          2: t = iv + mt;
          3: t = iv + mt + 1;
          default: t = mt;
        endcase
      end
      default: t = $urandom_range(mt, 4 * iv + mt + 2);
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] pick_command(input int user_pct, input bit allow_latch,
                                                      input int iv, input int mt);
    logic signed [31:0] c;
    case ($urandom_range(0, 9))
      0: c = HALT_VALUE;
      1: c = wps_pkg::CMD_FORCE_RESET;
      2: c = wps_pkg::CMD_OFF_OFF;
      3: c = allow_latch ? wps_pkg::CMD_OFF_ON : -2;
      4: c = 0 - int'($urandom_range(2, 99));
      5: c = ($urandom_range(0, 3) == 0) ? 32'sh8000_0000
                                         : -102 - int'($urandom_range(0, 1000000));
      default: begin
        c = pick_timeout(iv, mt);
        if ($urandom_range(0, 99) >= user_pct) c = HALT_VALUE;
        else if (c <= 0) c = $urandom_range(1, mt + 3);
      end
    endcase
    return c;
  endfunction

  // Random traffic: mostly a start followed by ticks, enough to run out a timeout
  // under 60, the rest single commands, pets, restarts and noise.
  task automatic run_phase(input int n, input int user_pct, input bit allow_latch);
    int                 stop_at;
    int                 pick;
    int                 n_ticks;
    int                 iv;
    int                 mt;
    logic [2:0]         op;
    logic signed [31:0] v;
    stop_at = items_offered + n;
    while (items_offered < stop_at) begin
      iv = (sb.pet_interval == 8'd0) ? 1 : sb.pet_interval;
      mt = sb.minimum_time;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        v = pick_timeout(iv, mt);
        if ($urandom_range(0, 99) < user_pct) begin
          if (v <= 0) v = $urandom_range(1, mt + 3);
          offer_item(wps_pkg::OP_CMD, v);
        end else begin
          offer_item(wps_pkg::OP_KSTART, v);
        end
        n_ticks = (v > 0 && v < 60) ? v + $urandom_range(0, 3) : $urandom_range(1, 12);
        repeat (n_ticks) begin
          if ($urandom_range(0, 11) == 0) offer_item(wps_pkg::OP_PET, $urandom);
          else offer_item(wps_pkg::OP_TICK, $urandom);
        end
      end else if (pick < 73) begin
        offer_item(wps_pkg::OP_TICK, $urandom);
      end else if (pick < 85) begin
        offer_item(wps_pkg::OP_CMD, pick_command(user_pct, allow_latch, iv, mt));
      end else if (pick < 90) begin
        offer_item(wps_pkg::OP_PET, $urandom);
      end else if (pick < 94) begin
        offer_item(wps_pkg::OP_RESTART, $urandom);
      end else begin
        // Any opcode but a user command, with a raw value.
        op = 3'($urandom_range(0, 6));
        if (op >= wps_pkg::OP_CMD) op = op + 3'd1;
        offer_item(op, $urandom);
      end
    end
  endtask

  // Output side: random stall before each result, then take it and check it.
  initial begin
    int w;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      w = rx_burst ? 0 : $urandom_range(0, 7);
      if (w > 0) begin
        rx_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      rx_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid === 1'b1 && result_stall === 1'b0));
      sb.check_result(result);
      @(negedge clk);
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    wait (hold_req === 1'b1);
    @(negedge clk);
    hold_long <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_long <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_watchdog_pet_supervisor: errors");
    $finish;
  end

  initial begin
    wps_pkg::cfg_t plan [0:6];
    plan[0] = '{8'd3,   8'd1,   1'b1, 1'b0, 1'b0};
    plan[1] = '{8'd1,   8'd1,   1'b1, 1'b0, 1'b0};
    plan[2] = '{8'd255, 8'd255, 1'b1, 1'b0, 1'b0};
    plan[3] = '{8'd5,   8'd2,   1'b1, 1'b1, 1'b0};
    plan[4] = '{8'd4,   8'd1,   1'b0, 1'b0, 1'b0};
    plan[5] = '{8'd6,   8'd3,   1'b1, 1'b0, 1'b1};
    plan[6] = '{8'd0,   8'd1,   1'b1, 1'b0, 1'b0};

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset register values. A start below the
    // minimum before any interval exists leaves a zero countdown, so the
    // next tick expires straight into a reset.
    offer_item(wps_pkg::OP_KSTART, 0);
    offer_item(wps_pkg::OP_TICK, 0);
    // A timeout shorter than one pet period runs once, then resets.
    offer_item(wps_pkg::OP_KSTART, 3);
    repeat (3) offer_item(wps_pkg::OP_TICK, 0);
    offer_item(wps_pkg::OP_PET, 0);
    offer_item(wps_pkg::OP_CMD, HALT_VALUE);
    offer_item(wps_pkg::OP_CMD, wps_pkg::CMD_OFF_OFF);
    offer_item(wps_pkg::OP_CMD, -5);
    offer_item(wps_pkg::OP_CMD, 32'sh8000_0000);
    offer_item(wps_pkg::OP_CMD, wps_pkg::CMD_FORCE_RESET);
    offer_item(wps_pkg::OP_KSTART, 32'sh7FFF_FFFF);
    offer_item(wps_pkg::OP_TICK, 0);
    offer_item(wps_pkg::OP_RESTART, 0);
    offer_item(wps_pkg::OP_CMD, 250);
    offer_item(wps_pkg::OP_TICK, 0);
    offer_item(OP_UNUSED_FIRST, 32'sh7FFF_FFFF);
    offer_item(OP_UNUSED_FIRST + 3'd1, 32'sh8000_0000);
    offer_item(OP_UNUSED_FIRST + 3'd2, -1);
    // Negative kernel timeout: below the minimum, keeps the last interval.
    offer_item(wps_pkg::OP_KSTART, -7);
    offer_item(wps_pkg::OP_TICK, 0);

    // Random phases over a range of register settings. The first one runs
    // with a back-to-back sender while the receiver holds off.
    foreach (plan[p]) begin
      apply_cfg(plan[p]);
      if (p == 0) begin
        tx_burst = 1'b1;
        hold_req = 1'b1;
      end
      run_phase(45, 20, 1'b0);
    end

    // Last phase: force offline through the latch, then spend the start budget.
    apply_cfg('{8'd7, 8'd2, 1'b1, 1'b0, 1'b0});
    run_phase(30, 20, 1'b0);
    offer_item(wps_pkg::OP_CMD, wps_pkg::CMD_OFF_ON);
    offer_item(wps_pkg::OP_PET, 0);
    offer_item(wps_pkg::OP_KSTART, 10);
    offer_item(wps_pkg::OP_CMD, HALT_VALUE);
    offer_item(wps_pkg::OP_CMD, wps_pkg::CMD_OFF_OFF);
    offer_item(wps_pkg::OP_CMD, wps_pkg::CMD_OFF_ON);
    offer_item(wps_pkg::OP_RESTART, 0);
    offer_item(wps_pkg::OP_TICK, 0);
    repeat (24) begin
      offer_item(wps_pkg::OP_CMD, $urandom_range(1, 5000));
      offer_item(wps_pkg::OP_TICK, $urandom);
    end
    run_phase(30, 50, 1'b1);

    drain();
    if (sb.errors == 0) begin
      $display("tb_watchdog_pet_supervisor: clean");
    end else begin
      $display("tb_watchdog_pet_supervisor: errors");
    end
    $finish;
  end

endmodule
